### rtl/rls_pkg.sv
package rls_pkg;

    localparam int LED_COUNT = 64;
    localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int WORD_W    = 24;
    localparam int BIT_W     = 5;
    localparam int TICK_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(WORD_W - 1);
    localparam logic [LED_W-1:0] LAST_LED = LED_W'(LED_COUNT - 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_SHOW  = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_HIGH  = 3'd0,
        CFG_ONE_LOW   = 3'd1,
        CFG_ZERO_HIGH = 3'd2,
        CFG_ZERO_LOW  = 3'd3,
        CFG_LATCH     = 3'd4
    } t_cfg_idx;

endpackage

### rtl/rls_ram.sv
module rls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rgb_led_strip_serializer.sv
// Single-wire RGB LED strip driver. Pixel words (green, red, blue) live in a
// 64-entry synchronous RAM; a write beat stores one pixel while the block is
// idle, a show beat starts a frame and every tick beat is one clock of the
// pulse timebase. Each bit goes out green first, MSB first, as a high pulse
// then a low pulse whose lengths come from the timing registers, and the
// frame ends with the latch low time. Every input beat gives exactly one
// result beat, held in an output register: the line level, busy and a flag
// for a write or show that was dropped (busy, or index out of range). One
// beat is taken every clock while the output side keeps up; a result left
// waiting in the output register holds off the input until it is taken, and
// ready follows the output side directly so that a taken result and a new
// beat share one cycle. Each result appears in the output register on the
// cycle after its beat. The word of the LED being sent is held in a register
// while the RAM fetches the next LED ahead of use; a fresh word is needed at
// most once every 48 ticks, so the single read port never limits the rate. The
// store reads as zero after reset through one valid flop per entry, so there is
// no clearing pass. Timing registers are written through the configuration
// port; the user must write them only while idle, the block does not enforce it.
module rgb_led_strip_serializer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic [7:0]                    i_led_index,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_line_level,
    output logic                          o_busy_res,
    output logic                          o_ignored,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [rls_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rls_pkg::CFG_W-1:0]     i_cfg_data
);
    import rls_pkg::*;

    // timing registers
    logic [7:0]        r_one_high;
    logic [7:0]        r_one_low;
    logic [7:0]        r_zero_high;
    logic [7:0]        r_zero_low;
    logic [TICK_W-1:0] r_latch;

    // frame sequencer
    t_phase            r_phase, n_phase;
    logic [LED_W-1:0]  r_led, n_led;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [WORD_W-1:0] r_word, n_word;

    // store side
    logic [LED_COUNT-1:0] r_valid_bits;
    logic                 r_rd_vld;
    logic [WORD_W-1:0]    rd_data;
    logic [WORD_W-1:0]    rd_word;
    logic [LED_W-1:0]     rd_addr;
    logic [LED_W-1:0]     wr_addr;
    logic [WORD_W-1:0]    wr_word;

    // result register
    logic r_o_valid;
    logic r_o_line;
    logic r_o_busy;
    logic r_o_ign;

    // beat decode
    logic              accept;
    logic              busy;
    logic              idx_ok;
    logic              do_write;
    logic              do_start;
    logic              do_tick;
    logic              ign;
    logic              cur_bit;
    logic [TICK_W-1:0] seg_len;
    logic [TICK_W-1:0] tick_inc;
    logic              seg_done;
    logic              last_bit;
    logic              last_led;
    logic              led_adv;

    assign o_ready  = !r_o_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign busy     = (r_phase != PH_IDLE);
    assign idx_ok   = (32'(i_led_index) < 32'(LED_COUNT));

    assign do_write = accept && (i_mode == MODE_WRITE) && !busy && idx_ok;
    assign do_start = accept && (i_mode == MODE_SHOW) && !busy;
    assign do_tick  = accept && (i_mode == MODE_TICK) && busy;
    assign ign      = accept && (((i_mode == MODE_WRITE) && (busy || !idx_ok))
                               || ((i_mode == MODE_SHOW) && busy));

    assign wr_addr  = LED_W'(i_led_index);
    assign wr_word  = {i_green, i_red, i_blue};

    // current bit, msb first
    assign cur_bit  = r_word[LAST_BIT - r_bit];
    assign last_bit = (r_bit == LAST_BIT);
    assign last_led = (r_led == LAST_LED);

    always_comb begin
        case (r_phase)
            PH_HIGH:  seg_len = TICK_W'(cur_bit ? r_one_high : r_zero_high);
            PH_LOW:   seg_len = TICK_W'(cur_bit ? r_one_low : r_zero_low);
            default:  seg_len = r_latch;
        endcase
    end

    // a zero length leaves after one tick, same as a length of one
    assign tick_inc = r_tick + TICK_W'(1);
    assign seg_done = (tick_inc >= seg_len);

    // moving on to the next led (or into the latch time)
    assign led_adv  = do_tick && seg_done && (r_phase == PH_LOW) && last_bit;

    // next state
    always_comb begin
        n_phase = r_phase;
        if (do_start) begin
            n_phase = PH_HIGH;
        end else if (do_tick && seg_done) begin
            case (r_phase)
                PH_HIGH:  n_phase = PH_LOW;
                PH_LOW:   n_phase = (last_bit && last_led) ? PH_LATCH : PH_HIGH;
                PH_LATCH: n_phase = PH_IDLE;
                default:  n_phase = r_phase;
            endcase
        end
    end

    // pointers, tick counter and current word
    always_comb begin
        n_tick = r_tick;
        n_bit  = r_bit;
        n_led  = r_led;
        n_word = r_word;
        if (do_start) begin
            n_tick = '0;
            n_bit  = '0;
            n_led  = '0;
        end else if (do_tick) begin
            n_tick = seg_done ? '0 : tick_inc;
            if (seg_done && (r_phase == PH_LOW)) begin
                n_bit = last_bit ? '0 : r_bit + BIT_W'(1);
                if (last_bit) begin
                    n_led = last_led ? '0 : r_led + LED_W'(1);
                end
            end
            if (seg_done && (r_phase == PH_LATCH)) begin
                n_bit = '0;
                n_led = '0;
            end
        end
        // the word register shadows entry zero while idle
        if (do_write && (wr_addr == '0)) begin
            n_word = wr_word;
        end else if (led_adv) begin
            n_word = rd_word;
        end
    end

    // fetch the next led one ahead; during the last led and the latch time
    // entry zero is fetched so the word register is back on it at the end
    assign rd_addr = (busy && (r_phase != PH_LATCH) && !last_led)
                   ? r_led + LED_W'(1) : '0;
    assign rd_word = r_rd_vld ? rd_data : '0;

    rls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LED_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (wr_addr),
        .i_wdata (wr_word),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid_bits[rd_addr];
        r_o_line <= accept ? (n_phase == PH_HIGH) : r_o_line;
        r_o_busy <= accept ? (n_phase != PH_IDLE) : r_o_busy;
        r_o_ign  <= accept ? ign : r_o_ign;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_led        <= '0;
            r_bit        <= '0;
            r_tick       <= '0;
            r_word       <= '0;
            r_valid_bits <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_led   <= n_led;
            r_bit   <= n_bit;
            r_tick  <= n_tick;
            r_word  <= n_word;
            if (do_write) begin
                r_valid_bits[wr_addr] <= 1'b1;
            end
            if (accept) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_high  <= 8'd9;
            r_one_low   <= 8'd4;
            r_zero_high <= 8'd3;
            r_zero_low  <= 8'd10;
            r_latch     <= TICK_W'(960);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ONE_HIGH:  r_one_high  <= i_cfg_data[7:0];
                CFG_ONE_LOW:   r_one_low   <= i_cfg_data[7:0];
                CFG_ZERO_HIGH: r_zero_high <= i_cfg_data[7:0];
                CFG_ZERO_LOW:  r_zero_low  <= i_cfg_data[7:0];
                CFG_LATCH:     r_latch     <= i_cfg_data[TICK_W-1:0];
                default:       ;
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_line_level = r_o_line;
    assign o_busy_res   = r_o_busy;
    assign o_ignored    = r_o_ign;

    // the store is only written between frames
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |-> (r_phase == PH_IDLE))
        else $error("pixel store written during a frame");

    // a show from idle is answered with the line high
    a_show_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_start |=> (o_valid && o_line_level && o_busy_res && !o_ignored))
        else $error("frame start not reported as high pulse");

    // pointers are back at the first led once a frame is over
    a_end_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && (n_phase == PH_IDLE)) |=> ((r_led == '0) && (r_bit == '0)))
        else $error("pointers not rewound at end of frame");

    // bit pointer stays within one colour word
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_tick |=> (r_bit <= LAST_BIT))
        else $error("bit pointer beyond the colour word");

endmodule
